>>> src/tbbt_pkg.sv
// ----------------------------------------------------------------------------
// tbbt_pkg
// shared constants and types of the turtle bounding box tracker
// ----------------------------------------------------------------------------
package tbbt_pkg;

	localparam int STACK_DEPTH_DEF  = 64;
	localparam int SINE_ENTRIES_DEF = 1024;

	// pipeline registers between input beat and position update
	localparam int NST = 9;

	localparam int OUT_W = 216;

	localparam logic [7:0] SYM_F     = 8'h46;
	localparam logic [7:0] SYM_G     = 8'h47;
	localparam logic [7:0] SYM_HOME  = 8'h23;
	localparam logic [7:0] SYM_PLUS  = 8'h2b;
	localparam logic [7:0] SYM_MINUS = 8'h2d;
	localparam logic [7:0] SYM_PUSH  = 8'h5b;
	localparam logic [7:0] SYM_POP   = 8'h5d;

	localparam logic [7:0] REG_ANGLE_STEP = 8'd0;
	localparam logic [7:0] REG_INIT_ANGLE = 8'd1;

	localparam logic [15:0] ANGLE_STEP_RST = 16'd16384;
	localparam logic [15:0] INIT_ANGLE_RST = 16'd0;

	localparam logic [1:0] FAULT_NONE  = 2'd0;
	localparam logic [1:0] FAULT_FULL  = 2'd1;
	localparam logic [1:0] FAULT_EMPTY = 2'd2;

	// quarter and half turn of the 16-bit heading
	localparam logic [15:0] QUARTER_TURN = 16'h4000;
	localparam logic [15:0] HALF_TURN    = 16'h8000;

	// sine polynomial coefficients, q14
	localparam logic [14:0] SIN_A = 15'd25736;
	localparam logic [13:0] SIN_B = 14'd10512;
	localparam logic [10:0] SIN_C = 11'd1160;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_STEP,
		OP_HOME,
		OP_SUB,
		OP_ADD,
		OP_PUSH,
		OP_POP
	} op_t;

endpackage

>>> src/turtle_bounding_box_tracker.sv
// ----------------------------------------------------------------------------
// turtle_bounding_box_tracker
// turtle interpreter for drawing symbols with position stack and bounding box
// ----------------------------------------------------------------------------
// one symbol enters per beat on the s_axis channel; every symbol gives one
// result beat on m_axis with position, heading, bounding box and stack fault
// throughput is one symbol per cycle while the output is not stalled; the
// sine/cosine unit is a nine-register pipeline and position takes a single
// read-modify-write per cycle
// headings are resolved at the input; popped headings come from the heading
// stack memory as a registered read and are forwarded to the next symbol
// popped positions are read from the position stack memory one stage ahead of
// the position update, with forwarding from a push in the update stage
// cfg writes set angle_step (index 0) and initial_angle (index 1); cfg_ready
// is always high and writes belong to idle periods
// reset: position, heading, box and stack are cleared, registers take their
// defaults; stack contents stay undefined and are never read before a push
// when m_axis_tready is low the pipeline keeps moving until all stages and the
// output register are full, then s_axis_tready drops
// ----------------------------------------------------------------------------
module turtle_bounding_box_tracker #(
	parameter int STACK_DEPTH  = tbbt_pkg::STACK_DEPTH_DEF,
	parameter int SINE_ENTRIES = tbbt_pkg::SINE_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,  // symbol
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// pos_x, pos_y, heading, box_min_x, box_max_x, box_min_y, box_max_y,
	// stack_fault, zero pad
	output logic [tbbt_pkg::OUT_W-1:0]  m_axis_tdata,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [7:0]                  cfg_index,
	input  logic [15:0]                 cfg_data
);
	import tbbt_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef struct packed {
		op_t           op;
		logic          push_ok;
		logic          pop_ok;
		logic [1:0]    fault;
		logic [AW-1:0] addr;
		logic [15:0]   heading;
	} ctl_t;

	logic [15:0]   angle_step_q;
	logic [15:0]   init_angle_q;
	logic [15:0]   heading_q;
	logic          pend_q;
	logic [15:0]   hd_rd_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_m1;

	logic [NST:1]  v_q;
	logic [NST:1]  adv;
	logic [NST:1]  ld;
	ctl_t          ctl_q [1:NST];
	ctl_t          ctl_in;
	ctl_t          ctl_hd;
	ctl_t          ce;

	logic [15:0]   hd_mem [STACK_DEPTH];
	logic [63:0]   xy_mem [STACK_DEPTH];
	logic [63:0]   xy_rd_q;
	logic          fwd_q;

	logic          acc;
	op_t           op;
	logic [15:0]   heading_eff;
	logic [15:0]   heading_new;
	logic          push_ok;
	logic          pop_ok;

	logic signed [15:0] cos_v;
	logic signed [15:0] sin_v;

	logic signed [31:0] x_q, y_q;
	logic signed [31:0] bminx_q, bmaxx_q, bminy_q, bmaxy_q;
	logic signed [31:0] xn, yn;

	logic               out_valid_q;
	logic signed [31:0] ox_q, oy_q, ominx_q, omaxx_q, ominy_q, omaxy_q;
	logic [15:0]        ohd_q;
	logic [1:0]         ofault_q;

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
	                                               input logic signed [15:0] b);
		logic [32:0] s;
		s = {a[31], a} + {{17{b[15]}}, b};
		if (s[32] != s[31]) begin
			sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			sat_add = signed'(s[31:0]);
		end
	endfunction

	// config port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_step_q <= ANGLE_STEP_RST;
			init_angle_q <= INIT_ANGLE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ANGLE_STEP: angle_step_q <= cfg_data;
				REG_INIT_ANGLE: init_angle_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow
	always_comb begin
		adv[NST] = v_q[NST] & (~out_valid_q | m_axis_tready);
		for (int i = NST - 1; i >= 1; i--) begin
			adv[i] = v_q[i] & (~v_q[i+1] | adv[i+1]);
		end
	end

	assign s_axis_tready = ~v_q[1] | adv[1];
	assign acc           = s_axis_tvalid & s_axis_tready;

	always_comb begin
		ld[1] = acc;
		for (int i = 2; i <= NST; i++) begin
			ld[i] = adv[i-1];
		end
	end

	// symbol decode and heading resolution
	always_comb begin
		unique case (s_axis_tdata) inside
			SYM_F, SYM_G: op = OP_STEP;
			SYM_HOME:     op = OP_HOME;
			SYM_PLUS:     op = OP_SUB;
			SYM_MINUS:    op = OP_ADD;
			SYM_PUSH:     op = OP_PUSH;
			SYM_POP:      op = OP_POP;
			default:      op = OP_NONE;
		endcase
	end

	assign heading_eff = pend_q ? hd_rd_q : heading_q;
	assign push_ok     = (op == OP_PUSH) && (count_q < CW'(STACK_DEPTH));
	assign pop_ok      = (op == OP_POP) && (count_q != '0);
	assign count_m1    = count_q - CW'(1);

	always_comb begin
		case (op)
			OP_HOME: heading_new = init_angle_q;
			OP_SUB:  heading_new = heading_eff - angle_step_q;
			OP_ADD:  heading_new = heading_eff + angle_step_q;
			default: heading_new = heading_eff;
		endcase
		ctl_in.op      = op;
		ctl_in.push_ok = push_ok;
		ctl_in.pop_ok  = pop_ok;
		ctl_in.fault   = FAULT_NONE;
		if ((op == OP_PUSH) && !push_ok) begin
			ctl_in.fault = FAULT_FULL;
		end
		if ((op == OP_POP) && !pop_ok) begin
			ctl_in.fault = FAULT_EMPTY;
		end
		ctl_in.addr    = pop_ok ? count_m1[AW-1:0] : count_q[AW-1:0];
		ctl_in.heading = heading_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= INIT_ANGLE_RST;
			pend_q    <= 1'b0;
			count_q   <= '0;
			v_q       <= '0;
		end else begin
			if (acc) begin
				heading_q <= heading_new;
				pend_q    <= pop_ok;
				if (push_ok) begin
					count_q <= count_q + CW'(1);
				end else if (pop_ok) begin
					count_q <= count_m1;
				end
			end
			for (int i = 1; i <= NST; i++) begin
				v_q[i] <= ld[i] | (v_q[i] & ~adv[i]);
			end
		end
	end

	// heading stack
	always_ff @(posedge clk) begin
		if (acc && push_ok) begin
			hd_mem[ctl_in.addr] <= heading_eff;
		end
		if (acc && pop_ok) begin
			hd_rd_q <= hd_mem[ctl_in.addr];
		end
	end

	// popped heading joins at the second stage
	always_comb begin
		ctl_hd = ctl_q[1];
		if (ctl_q[1].pop_ok) begin
			ctl_hd.heading = hd_rd_q;
		end
	end

	// control line
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			ctl_q[1] <= ctl_in;
		end
		if (ld[2]) begin
			ctl_q[2] <= ctl_hd;
		end
		for (int i = 3; i <= NST; i++) begin
			if (ld[i]) begin
				ctl_q[i] <= ctl_q[i-1];
			end
		end
	end

	tbbt_sine #(
		.SINE_ENTRIES (SINE_ENTRIES)
	) u_sine (
		.clk     (clk),
		.heading (heading_eff),
		.ld      (ld),
		.cos_val (cos_v),
		.sin_val (sin_v)
	);

	// position stack, read one stage ahead of the update
	always_ff @(posedge clk) begin
		if (ld[NST] && ctl_q[NST-1].pop_ok) begin
			xy_rd_q <= xy_mem[ctl_q[NST-1].addr];
			fwd_q   <= adv[NST] && ctl_q[NST].push_ok
			           && (ctl_q[NST].addr == ctl_q[NST-1].addr);
		end
		if (adv[NST] && ctl_q[NST].push_ok) begin
			xy_mem[ctl_q[NST].addr] <= {y_q, x_q};
		end
	end

	// position update
	assign ce = ctl_q[NST];

	always_comb begin
		xn = x_q;
		yn = y_q;
		case (ce.op)
			OP_STEP: begin
				xn = sat_add(x_q, cos_v);
				yn = sat_add(y_q, sin_v);
			end
			OP_HOME: begin
				xn = '0;
				yn = '0;
			end
			OP_POP: begin
				if (ce.pop_ok && !fwd_q) begin
					xn = signed'(xy_rd_q[31:0]);
					yn = signed'(xy_rd_q[63:32]);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= '0;
			y_q         <= '0;
			bminx_q     <= '0;
			bmaxx_q     <= '0;
			bminy_q     <= '0;
			bmaxy_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv[NST]) begin
				x_q     <= xn;
				y_q     <= yn;
				bminx_q <= (xn < bminx_q) ? xn : bminx_q;
				bmaxx_q <= (xn > bmaxx_q) ? xn : bmaxx_q;
				bminy_q <= (yn < bminy_q) ? yn : bminy_q;
				bmaxy_q <= (yn > bmaxy_q) ? yn : bmaxy_q;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NST]) begin
			ox_q     <= xn;
			oy_q     <= yn;
			ohd_q    <= ce.heading;
			ominx_q  <= (xn < bminx_q) ? xn : bminx_q;
			omaxx_q  <= (xn > bmaxx_q) ? xn : bmaxx_q;
			ominy_q  <= (yn < bminy_q) ? yn : bminy_q;
			omaxy_q  <= (yn > bmaxy_q) ? yn : bmaxy_q;
			ofault_q <= ce.fault;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, ofault_q, omaxy_q, ominy_q, omaxx_q, ominx_q,
	                        ohd_q, oy_q, ox_q};

endmodule

>>> src/tbbt_sine.sv
// ----------------------------------------------------------------------------
// tbbt_sine
// pipelined table phase and sine/cosine polynomial of one heading per beat
// ----------------------------------------------------------------------------
module tbbt_sine #(
	parameter int SINE_ENTRIES = tbbt_pkg::SINE_ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic [15:0]               heading,
	input  logic [tbbt_pkg::NST-1:0]  ld,
	output logic signed [15:0]        cos_val,
	output logic signed [15:0]        sin_val
);
	import tbbt_pkg::*;

	localparam int NW = $clog2(SINE_ENTRIES + 1);
	localparam longint unsigned RECIP = 64'd4294967296 / 64'(SINE_ENTRIES);
	localparam int RW = $clog2(RECIP + 1);

	logic [15+NW:0] hn;
	logic [15:0]    k_s1, k_s2, k_s3;
	logic [15+RW:0] kr_s2;
	logic [15:0]    q0_s3;
	logic [15+NW:0] qn_s3;
	logic [32:0]    rem;
	logic [15:0]    p_s4;

	logic [15:0] ph   [2];
	logic [14:0] uf   [2];
	logic [15:0] uneg [2];
	logic [29:0] uu   [2];
	logic [25:0] cz   [2];
	logic [13:0] t1   [2];
	logic [28:0] mz   [2];
	logic [14:0] t2   [2];
	logic [29:0] ut   [2];

	logic [14:0] u_s5 [2];
	logic [14:0] z2_s5 [2];
	logic        neg_s5 [2];
	logic [14:0] u_s6 [2];
	logic [14:0] z2_s6 [2];
	logic [25:0] c_s6 [2];
	logic        neg_s6 [2];
	logic [14:0] u_s7 [2];
	logic [28:0] m_s7 [2];
	logic        neg_s7 [2];
	logic [29:0] r_s8 [2];
	logic        neg_s8 [2];
	logic signed [15:0] val_s9 [2];

	assign hn  = {{NW{1'b0}}, heading} * (16 + NW)'(SINE_ENTRIES);
	assign rem = {1'b0, k_s3, 16'h0000} - 33'(qn_s3);

	// lane 0 is cosine, lane 1 is sine
	always_comb begin
		ph[0] = p_s4 + QUARTER_TURN;
		ph[1] = p_s4;
		for (int i = 0; i < 2; i++) begin
			uneg[i] = HALF_TURN - {1'b0, ph[i][14:0]};
			uf[i]   = (ph[i][14:0] > QUARTER_TURN[14:0]) ? uneg[i][14:0] : ph[i][14:0];
			uu[i]   = uf[i] * uf[i];
			cz[i]   = SIN_C * z2_s5[i];
			t1[i]   = SIN_B - 14'(c_s6[i] >> 14);
			mz[i]   = t1[i] * z2_s6[i];
			t2[i]   = SIN_A - 15'(m_s7[i] >> 14);
			ut[i]   = u_s7[i] * t2[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			k_s1 <= 16'(hn >> 16);
		end
		if (ld[1]) begin
			kr_s2 <= {{RW{1'b0}}, k_s1} * (16 + RW)'(RECIP);
			k_s2  <= k_s1;
		end
		if (ld[2]) begin
			q0_s3 <= 16'(kr_s2 >> 16);
			qn_s3 <= {{NW{1'b0}}, 16'(kr_s2 >> 16)} * (16 + NW)'(SINE_ENTRIES);
			k_s3  <= k_s2;
		end
		if (ld[3]) begin
			p_s4 <= q0_s3 + 16'(rem >= 33'(SINE_ENTRIES));
		end
		for (int i = 0; i < 2; i++) begin
			if (ld[4]) begin
				u_s5[i]   <= uf[i];
				z2_s5[i]  <= uu[i][28:14];
				neg_s5[i] <= ph[i][15];
			end
			if (ld[5]) begin
				u_s6[i]   <= u_s5[i];
				z2_s6[i]  <= z2_s5[i];
				c_s6[i]   <= cz[i];
				neg_s6[i] <= neg_s5[i];
			end
			if (ld[6]) begin
				u_s7[i]   <= u_s6[i];
				m_s7[i]   <= mz[i];
				neg_s7[i] <= neg_s6[i];
			end
			if (ld[7]) begin
				r_s8[i]   <= ut[i];
				neg_s8[i] <= neg_s7[i];
			end
			if (ld[8]) begin
				val_s9[i] <= neg_s8[i] ? -signed'({1'b0, r_s8[i][28:14]})
				                       : signed'({1'b0, r_s8[i][28:14]});
			end
		end
	end

	assign cos_val = val_s9[0];
	assign sin_val = val_s9[1];

endmodule
